// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property holds at every clock edge outside reset.
`define PPX_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define PPX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PPX_ASSERT_ALWAYS(label, clk, rstn, expr)
`define PPX_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/ppx_pkg.sv =====
`timescale 1ns / 1ps

package ppx_pkg;

    localparam int MAX_INDEX_BITS_DEFAULT = 8;

    localparam int PAL_DEPTH   = 256;
    localparam int PAL_ADDR_W  = 8;
    localparam int COLOR_W     = 16;
    localparam int CHAN_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int IB_W        = 4;
    localparam int PPF_W       = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int RUN_W       = 4;
    localparam int MAX_RUN     = 8;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INDEX_BITS       = 3'd0,
        CFG_PIXELS_PER_FRAME = 3'd1,
        CFG_MASK_RED         = 3'd2,
        CFG_MASK_GREEN       = 3'd3,
        CFG_MASK_BLUE        = 3'd4
    } cfg_reg_e;

    // Commands from the sequencer to the unpack unit.
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } ppx_unpack_cmd_t;

    // Status from the unpack unit back to the sequencer.
    typedef struct packed {
        logic                  avail;
        logic                  more;
        logic [PAL_ADDR_W-1:0] index;
    } ppx_unpack_sts_t;

endpackage

// ===== hdl/ppx_palette.sv =====
`timescale 1ns / 1ps

module ppx_palette (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ppx_pkg::PAL_ADDR_W-1:0] wr_addr,
    input  logic [ppx_pkg::COLOR_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [ppx_pkg::PAL_ADDR_W-1:0] rd_addr,
    output logic [ppx_pkg::COLOR_W-1:0]    rd_data
);
    import ppx_pkg::*;

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ppx_unpack.sv =====
`timescale 1ns / 1ps

module ppx_unpack #(
    parameter int MAX_INDEX_BITS = ppx_pkg::MAX_INDEX_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ppx_pkg::ppx_unpack_cmd_t              cmd,
    input  logic [ppx_pkg::BYTE_W-1:0]            data_byte,
    input  logic [$clog2(MAX_INDEX_BITS+1)-1:0]   nb,
    output ppx_pkg::ppx_unpack_sts_t              sts
);
    import ppx_pkg::*;

    localparam int AccW  = MAX_INDEX_BITS + 7;
    localparam int HeldW = $clog2(MAX_INDEX_BITS + 8);

    logic [AccW-1:0]  acc_reg, acc_next;
    logic [HeldW-1:0] held_reg, held_next;

    logic [AccW-1:0]  acc_base;
    logic [HeldW-1:0] held_base;
    logic [HeldW:0]   held_sum;
    logic [HeldW-1:0] held_after;
    logic [AccW-1:0]  shifted;
    logic [AccW-1:0]  field;

    // One index is pulled per step: the shared shifter aligns the top unread
    // field to bit zero and the mask keeps only the index width.
    always_comb begin
        acc_base   = cmd.clear ? '0 : acc_reg;
        held_base  = cmd.clear ? '0 : held_reg;
        held_sum   = {1'b0, held_base} + (HeldW+1)'(BYTE_W);
        held_after = held_reg - HeldW'(nb);
        shifted    = acc_reg >> held_after;
        field      = shifted & ~({AccW{1'b1}} << nb);

        acc_next  = acc_reg;
        held_next = held_reg;
        if (cmd.load) begin
            acc_next = AccW'({acc_base, data_byte});
            if (held_sum > (HeldW+1)'(AccW)) begin
                held_next = HeldW'(AccW);
            end else begin
                held_next = held_sum[HeldW-1:0];
            end
        end else if (cmd.step) begin
            acc_next  = acc_reg & ~({AccW{1'b1}} << held_after);
            held_next = held_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            held_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

    assign sts.avail = held_reg >= HeldW'(nb);
    assign sts.more  = held_after >= HeldW'(nb);
    assign sts.index = field[PAL_ADDR_W-1:0];

endmodule

// ===== hdl/packed_palette_pixel_expander.sv =====
`timescale 1ns / 1ps
// Packed palette pixel expander.
// The input channel (s_*) carries two kinds of transaction. A palette
// transaction stores a 5:6:5 color at an index of the 256-entry palette
// and leaves the block idle. A data transaction delivers one byte of packed
// color indices, read most significant bit first, index_bits wide each.
// Every complete index is looked up in the palette, widened to 8:8:8 and
// masked per channel, and leaves on the result channel (m_*) as one pixel.
// The unpack unit pulls one index per cycle, unless the pipeline is full,
// through a shared shifter under a small sequencer; s_ready stays low from
// the accept of a data transaction until its indices are walked and a
// closing step is done, so the next byte waits for the walk to end.
// The first pixel passes the loaded accumulator, the registered palette read
// and the output register. A pipeline stage and the output register decouple
// the sides: when the receiver stalls, the index walk stops as soon as both
// are full and no pixel is lost. Pixels beyond pixels_per_frame are still
// consumed but dropped. Reset clears the bit accumulator and the pixel count
// and sets the configuration to 8-bit indices, one pixel per frame and
// all-ones channel masks; palette contents stay undefined until written.
`include "assert_macros.svh"

module packed_palette_pixel_expander #(
    parameter int MAX_INDEX_BITS = ppx_pkg::MAX_INDEX_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [ppx_pkg::PAL_ADDR_W-1:0]    s_palette_index,
    input  logic [ppx_pkg::COLOR_W-1:0]       s_palette_color,
    input  logic [ppx_pkg::BYTE_W-1:0]        s_data_byte,
    input  logic                              s_frame_start,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppx_pkg::CHAN_W-1:0]        m_red,
    output logic [ppx_pkg::CHAN_W-1:0]        m_green,
    output logic [ppx_pkg::CHAN_W-1:0]        m_blue,
    output logic                              m_end_of_frame,
    output logic                              m_last_of_run,
    input  logic                              cfg_wr_en,
    input  logic [ppx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ppx_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import ppx_pkg::*;

    localparam int NbW = $clog2(MAX_INDEX_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [IB_W-1:0]   ib_reg;
    logic [PPF_W-1:0]  ppf_reg;
    logic [CHAN_W-1:0] mask_red_reg, mask_green_reg, mask_blue_reg;

    // Per-byte and per-frame counters.
    logic [RUN_W-1:0] n_reg, n_next;
    logic [PPF_W-1:0] pd_reg, pd_next;

    // Palette read stage and output register.
    logic rd_valid_reg, rd_valid_next;
    logic rd_eof_reg, rd_eof_next;
    logic rd_last_reg, rd_last_next;
    logic m_valid_reg;
    logic [CHAN_W-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic m_eof_reg, m_last_reg;

    ppx_unpack_cmd_t ucmd;
    ppx_unpack_sts_t ust;
    logic [NbW-1:0]  nb;
    logic [COLOR_W-1:0] rd_data;
    logic [PPF_W-1:0] pd_inc;
    logic [RUN_W-1:0] n_inc;
    logic out_free, rd_move, step_ok, emit, eof_c, n_full, pal_we;

    // An index width of zero means one; widths beyond the build limit clamp.
    always_comb begin
        if (ib_reg == '0) begin
            nb = NbW'(1);
        end else if (int'(ib_reg) > MAX_INDEX_BITS) begin
            nb = NbW'(MAX_INDEX_BITS);
        end else begin
            nb = NbW'(ib_reg);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign pal_we   = s_valid && s_ready && (s_kind == KIND_PALETTE);
    assign out_free = !m_valid_reg || m_ready;
    assign rd_move  = rd_valid_reg && out_free;
    assign step_ok  = !rd_valid_reg || out_free;
    assign pd_inc   = pd_reg + PPF_W'(1);
    assign n_inc    = n_reg + RUN_W'(1);
    assign n_full   = (n_reg == RUN_W'(MAX_RUN));
    assign eof_c    = (pd_inc == ppf_reg);

    // Sequencer: load the byte, walk the accumulator one index per unstalled cycle.
    always_comb begin
        state_next   = state_reg;
        ucmd         = '0;
        n_next       = n_reg;
        pd_next      = pd_reg;
        emit         = 1'b0;
        rd_eof_next  = rd_eof_reg;
        rd_last_next = rd_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_kind == KIND_DATA)) begin
                    ucmd.load  = 1'b1;
                    ucmd.clear = s_frame_start;
                    n_next     = '0;
                    if (s_frame_start) begin
                        pd_next = '0;
                    end
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (step_ok) begin
                    if (!ust.avail || n_full) begin
                        state_next = ST_IDLE;
                    end else begin
                        ucmd.step = 1'b1;
                        if (pd_reg < ppf_reg) begin
                            // This pixel closes the run if the frame fills,
                            // the run limit is hit or no further index remains.
                            emit         = 1'b1;
                            pd_next      = pd_inc;
                            n_next       = n_inc;
                            rd_eof_next  = eof_c;
                            rd_last_next = eof_c || (n_inc == RUN_W'(MAX_RUN)) || !ust.more;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        rd_valid_next = (rd_valid_reg && !rd_move) || emit;
    end

    ppx_unpack #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS)
    ) u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ucmd),
        .data_byte (s_data_byte),
        .nb        (nb),
        .sts       (ust)
    );

    ppx_palette u_palette (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .wr_addr (s_palette_index),
        .wr_data (s_palette_color),
        .rd_en   (emit),
        .rd_addr (ust.index),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ib_reg         <= IB_W'(8);
            ppf_reg        <= PPF_W'(1);
            mask_red_reg   <= '1;
            mask_green_reg <= '1;
            mask_blue_reg  <= '1;
            n_reg          <= '0;
            pd_reg         <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            pd_reg       <= pd_next;
            rd_valid_reg <= rd_valid_next;
            if (rd_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:       ib_reg         <= cfg_wr_data[IB_W-1:0];
                    CFG_PIXELS_PER_FRAME: ppf_reg        <= cfg_wr_data[PPF_W-1:0];
                    CFG_MASK_RED:         mask_red_reg   <= cfg_wr_data[CHAN_W-1:0];
                    CFG_MASK_GREEN:       mask_green_reg <= cfg_wr_data[CHAN_W-1:0];
                    CFG_MASK_BLUE:        mask_blue_reg  <= cfg_wr_data[CHAN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers: the 5:6:5 word is widened by left shifts and masked.
    always_ff @(posedge aclk) begin
        rd_eof_reg  <= rd_eof_next;
        rd_last_reg <= rd_last_next;
        if (rd_move) begin
            m_red_reg   <= {rd_data[15:11], 3'b000} & mask_red_reg;
            m_green_reg <= {rd_data[10:5], 2'b00} & mask_green_reg;
            m_blue_reg  <= {rd_data[4:0], 3'b000} & mask_blue_reg;
            m_eof_reg   <= rd_eof_reg;
            m_last_reg  <= rd_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red          = m_red_reg;
    assign m_green        = m_green_reg;
    assign m_blue         = m_blue_reg;
    assign m_end_of_frame = m_eof_reg;
    assign m_last_of_run  = m_last_reg;

    // The frame's final pixel always closes the run of its byte.
    `PPX_ASSERT_ALWAYS(a_eof_closes_run, aclk, aresetn,
        !m_valid || !m_end_of_frame || m_last_of_run)

    // A waiting pixel in the read stage is held while the output is blocked.
    `PPX_ASSERT_NEXT(a_rd_stage_holds, aclk, aresetn,
        rd_valid_reg && !out_free, rd_valid_reg && $stable(rd_last_reg))

    // One byte never yields more than the run limit of pixels.
    `PPX_ASSERT_ALWAYS(a_run_limit, aclk, aresetn, n_reg <= RUN_W'(MAX_RUN))

endmodule
